[design/skf_pkg.sv]
// Shared types, constants and the microcode ROM of the per-channel Kalman filter.
// No dependencies; every other design file imports this package.
package skf_pkg;

  // Field widths of the item payloads
  localparam int REQ_W   = 1;
  localparam int CHAN_W  = 4;
  localparam int SMP_W   = 16;
  localparam int VAL_W   = 24;
  localparam int R_W     = 8;
  localparam int NUM_SLOTS = 16;

  // Defaults for the top-level parameters
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // Register reset and saturation values
  localparam logic [R_W-1:0]   R_RESET = 8'd9;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // Request codes
  localparam logic [REQ_W-1:0] REQ_FILTER = 1'b0;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 1'b1;

  // Reset process noise, in hundredths, per table slot
  localparam logic [6:0] Q_INIT_HUND [NUM_SLOTS] = '{
    7'd58, 7'd60, 7'd63, 7'd53, 7'd51, 7'd53, 7'd50, 7'd52,
    7'd52, 7'd50, 7'd53, 7'd49, 7'd57, 7'd54, 7'd50, 7'd51
  };

  // Reset Q of one channel: round(h * 2^frac / 100), saturated
  function automatic logic [VAL_W-1:0] q_reset_value(input int idx, input int frac);
    longint v;
    v = ((longint'(Q_INIT_HUND[idx % NUM_SLOTS]) << frac) + 64'sd50) / 64'sd100;
    if (v > longint'(VAL_MAX)) begin
      return VAL_MAX;
    end
    return VAL_W'(v);
  endfunction

  // Microcode
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SUM,
    OP_DEN,
    OP_DIV,
    OP_GAIN_MUL,
    OP_COV_MUL,
    OP_ACC,
    OP_STORE,
    OP_ROUND,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ACCEPT,
    JC_LOOP,
    JC_WAIT_OUT
  } jc_t;

  typedef struct packed {
    op_t op;
    jc_t jc;
    pc_t target;
  } ucode_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_t  op;
    logic accept_en;
  } ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic filter_fire;
    logic cnt_nz;
    logic out_free;
  } stat_t;

  // Program addresses
  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_SUM   = 4'd1;
  localparam pc_t PC_DEN   = 4'd2;
  localparam pc_t PC_DIV   = 4'd3;
  localparam pc_t PC_GAIN  = 4'd4;
  localparam pc_t PC_COV   = 4'd5;
  localparam pc_t PC_ACC   = 4'd6;
  localparam pc_t PC_STORE = 4'd7;
  localparam pc_t PC_ROUND = 4'd8;
  localparam pc_t PC_EMIT  = 4'd9;

  // Program ROM: one control word per step
  function automatic ucode_t skf_rom(input pc_t pc);
    ucode_t uc;
    uc = '{op: OP_IDLE, jc: JC_ACCEPT, target: PC_SUM};
    unique case (pc)
      PC_IDLE:  uc = '{op: OP_IDLE,     jc: JC_ACCEPT,   target: PC_SUM};
      PC_SUM:   uc = '{op: OP_SUM,      jc: JC_NEXT,     target: PC_IDLE};
      PC_DEN:   uc = '{op: OP_DEN,      jc: JC_NEXT,     target: PC_IDLE};
      PC_DIV:   uc = '{op: OP_DIV,      jc: JC_LOOP,     target: PC_DIV};
      PC_GAIN:  uc = '{op: OP_GAIN_MUL, jc: JC_NEXT,     target: PC_IDLE};
      PC_COV:   uc = '{op: OP_COV_MUL,  jc: JC_NEXT,     target: PC_IDLE};
      PC_ACC:   uc = '{op: OP_ACC,      jc: JC_NEXT,     target: PC_IDLE};
      PC_STORE: uc = '{op: OP_STORE,    jc: JC_NEXT,     target: PC_IDLE};
      PC_ROUND: uc = '{op: OP_ROUND,    jc: JC_NEXT,     target: PC_IDLE};
      PC_EMIT:  uc = '{op: OP_EMIT,     jc: JC_WAIT_OUT, target: PC_IDLE};
      default:  uc = '{op: OP_IDLE,     jc: JC_WAIT_OUT, target: PC_IDLE};
    endcase
    return uc;
  endfunction

endpackage

[design/skf_stream_if.sv]
// Valid/ready channel interfaces for filter requests and estimates.
// Depends on skf_pkg for the field widths.
interface skf_in_if import skf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [CHAN_W-1:0]  channel;
  logic signed [SMP_W-1:0] raw_sample;
  logic signed [SMP_W-1:0] last_estimate;
  logic [VAL_W-1:0]   noise_value;

  modport source (output valid, req_type, channel, raw_sample, last_estimate, noise_value,
                  input ready);
  modport sink   (input valid, req_type, channel, raw_sample, last_estimate, noise_value,
                  output ready);
endinterface

interface skf_out_if import skf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] estimate;

  modport source (output valid, estimate, input ready);
  modport sink   (input valid, estimate, output ready);
endinterface

[design/channel_scalar_kalman_filter.sv]
// Top level of the per-channel scalar Kalman filter: datapath, per-channel stores.
// Depends on skf_pkg, skf_stream_if and skf_sequencer.
//
// Usage:
//   in_chan carries request items. A filter item (req_type 0) names a channel, a raw
//   sample and the last estimate; it yields one estimate item on out_chan. A write
//   item (req_type 1) loads the channel's process noise Q and yields nothing.
//   cfg_we/cfg_wdata load the shared observation noise R (write only while idle).
//   Channel numbers wrap modulo NUM_CHANNELS.
// Sequence:
//   A write item is taken in the idle step, which then stays ready for the next item.
//   A filter item keeps the block busy through sum, denominator, the restoring gain
//   divide (one quotient bit per cycle, FRAC_BITS + 1 bits), gain and covariance
//   multiplies, accumulate, store, round and emit; in_chan.ready is low meanwhile.
// Reset:
//   rst_n is synchronous and active low. It sets R to 9, every covariance to 1.0 and
//   every Q to its table value through per-entry valid bits; no clearing pass.
// Back-pressure:
//   The estimate sits in an output register. A stalled receiver holds the sequencer
//   on its last step until that register frees; in_chan.ready stays low meanwhile.
module channel_scalar_kalman_filter import skf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [R_W-1:0] cfg_wdata,
  skf_in_if.sink         in_chan,
  skf_out_if.source      out_chan
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PT_W   = VAL_W + 1;
  localparam int DEN_W  = ((FRAC_BITS + R_W > PT_W) ? FRAC_BITS + R_W : PT_W) + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int K_W    = FRAC_BITS + 1;
  localparam int DIFF_W = SMP_W + 1;
  localparam int NUM_W  = FRAC_BITS + SMP_W + 3;
  localparam int CP_W   = K_W + PT_W;
  localparam int PN_W   = CP_W - FRAC_BITS;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam logic [VAL_W-1:0] P_ONE =
    (FRAC_BITS >= VAL_W) ? VAL_MAX : VAL_W'(64'd1 << FRAC_BITS);
  localparam logic [K_W-1:0] K_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NUM_W-1:0] RND_BIAS =
    {{(NUM_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  // Sequencer link
  ctrl_t ctrl;
  stat_t stat;

  // Channel wrap table and reset Q table
  logic [CH_W-1:0]  ch_map      [NUM_SLOTS];
  logic [VAL_W-1:0] q_reset_tab [NUM_CHANNELS];

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_ch_map
    assign ch_map[i] = CH_W'(i % NUM_CHANNELS);
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_q_tab
    assign q_reset_tab[i] = q_reset_value(i, FRAC_BITS);
  end

  // Stores and their valid bits
  logic [VAL_W-1:0]        p_mem [NUM_CHANNELS];
  logic [VAL_W-1:0]        q_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] p_vld_r;
  logic [NUM_CHANNELS-1:0] q_vld_r;
  logic [VAL_W-1:0]        p_rd_r;
  logic [VAL_W-1:0]        q_rd_r;
  logic                    p_vld_rd_r;
  logic                    q_vld_rd_r;

  // Datapath registers
  logic [R_W-1:0]             r_noise_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [SMP_W-1:0]    last_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic [PT_W-1:0]            ptemp_r;
  logic [DEN_W-1:0]           den_r;
  logic [REM_W-1:0]           rem_r;
  logic [K_W-1:0]             quo_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [NUM_W-1:0]    gprod_r;
  logic [CP_W-1:0]            cprod_r;
  logic signed [NUM_W-1:0]    num_r;
  logic signed [SMP_W-1:0]    est_r;
  logic                       out_valid_r;
  logic signed [SMP_W-1:0]    out_est_r;

  // Combinational helpers
  logic                    in_fire;
  logic [CH_W-1:0]         ch_idx;
  logic [VAL_W-1:0]        p_val;
  logic [VAL_W-1:0]        q_val;
  logic                    div_ge;
  logic [REM_W-1:0]        rem_sub;
  logic [K_W-1:0]          k_gain;
  logic [K_W-1:0]          k_rest;
  logic [PN_W-1:0]         p_new;
  logic [VAL_W-1:0]        p_sat;
  logic signed [NUM_W-1:0] num_biased;
  logic                    out_free;

  assign in_chan.ready = ctrl.accept_en;
  assign in_fire  = in_chan.valid && ctrl.accept_en;
  assign ch_idx   = ch_map[in_chan.channel];
  assign out_free = !out_valid_r || out_chan.ready;

  assign stat.filter_fire = in_fire && (in_chan.req_type == REQ_FILTER);
  assign stat.cnt_nz      = (cnt_r != '0);
  assign stat.out_free    = out_free;

  skf_sequencer u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Entries never written read as their reset value
  assign p_val = p_vld_rd_r ? p_rd_r : P_ONE;
  assign q_val = q_vld_rd_r ? q_rd_r : q_reset_tab[ch_r];

  // Restoring divide step and gain clamp (a full quotient bit means exactly 1.0)
  assign div_ge  = (rem_r >= REM_W'(den_r));
  assign rem_sub = div_ge ? rem_r - REM_W'(den_r) : rem_r;
  assign k_gain  = quo_r[FRAC_BITS] ? K_ONE : quo_r;
  assign k_rest  = K_ONE - k_gain;

  // New covariance, saturated to the store width
  assign p_new = cprod_r[CP_W-1:FRAC_BITS];
  assign p_sat = (p_new[PN_W-1:VAL_W] != '0) ? VAL_MAX : p_new[VAL_W-1:0];

  // Truncate toward zero: bias negative values before the shift
  assign num_biased = num_r + (num_r[NUM_W-1] ? $signed(RND_BIAS) : $signed(NUM_W'(0)));

  // Covariance and noise memories
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_chan.req_type == REQ_WRITE) begin
        q_mem[ch_idx] <= in_chan.noise_value;
      end else begin
        p_rd_r <= p_mem[ch_idx];
        q_rd_r <= q_mem[ch_idx];
      end
    end
    if (ctrl.op == OP_STORE) begin
      p_mem[ch_r] <= p_sat;
    end
  end

  // Valid bits and their registered reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r    <= '0;
      q_vld_r    <= '0;
      p_vld_rd_r <= 1'b0;
      q_vld_rd_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_chan.req_type == REQ_WRITE) begin
          q_vld_r[ch_idx] <= 1'b1;
        end else begin
          p_vld_rd_r <= p_vld_r[ch_idx];
          q_vld_rd_r <= q_vld_r[ch_idx];
        end
      end
      if (ctrl.op == OP_STORE) begin
        p_vld_r[ch_r] <= 1'b1;
      end
    end
  end

  // Observation noise register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_noise_r <= R_RESET;
    end else if (cfg_we) begin
      r_noise_r <= cfg_wdata;
    end
  end

  // Arithmetic datapath driven by the control word
  always_ff @(posedge clk) begin
    if (stat.filter_fire) begin
      ch_r   <= ch_idx;
      last_r <= in_chan.last_estimate;
      diff_r <= DIFF_W'(in_chan.raw_sample) - DIFF_W'(in_chan.last_estimate);
    end
    case (ctrl.op)
      OP_SUM: begin
        ptemp_r <= PT_W'(p_val) + PT_W'(q_val);
      end
      OP_DEN: begin
        den_r <= DEN_W'(ptemp_r) + (DEN_W'(r_noise_r) << FRAC_BITS);
        rem_r <= REM_W'(ptemp_r);
        quo_r <= '0;
        cnt_r <= CNT_W'(FRAC_BITS);
      end
      OP_DIV: begin
        rem_r <= {rem_sub[REM_W-2:0], 1'b0};
        quo_r <= {quo_r[K_W-2:0], div_ge};
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      OP_GAIN_MUL: begin
        gprod_r <= $signed({1'b0, k_gain}) * NUM_W'(diff_r);
      end
      OP_COV_MUL: begin
        cprod_r <= CP_W'(k_rest) * CP_W'(ptemp_r);
      end
      OP_ACC: begin
        num_r <= (NUM_W'(last_r) <<< FRAC_BITS) + gprod_r;
      end
      OP_ROUND: begin
        est_r <= num_biased[FRAC_BITS +: SMP_W];
      end
      default: begin
      end
    endcase
  end

  // Output register: load on the last step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && out_free) begin
      out_est_r <= est_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.estimate = out_est_r;

endmodule

[design/skf_sequencer.sv]
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on skf_pkg for the ROM, control and status types.
module skf_sequencer import skf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  ucode_t uc;

  // Fetch the control word of the current step
  assign uc = skf_rom(pc_r);
  assign ctrl.op = uc.op;
  assign ctrl.accept_en = (uc.jc == JC_ACCEPT);

  // Select the next step
  always_comb begin
    unique case (uc.jc)
      JC_NEXT:     pc_nxt = pc_r + PC_W'(1);
      JC_ACCEPT:   pc_nxt = stat.filter_fire ? uc.target : pc_r;
      JC_LOOP:     pc_nxt = stat.cnt_nz ? uc.target : pc_r + PC_W'(1);
      JC_WAIT_OUT: pc_nxt = stat.out_free ? uc.target : pc_r;
      default:     pc_nxt = PC_IDLE;
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[bench/channel_scalar_kalman_filter_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for channel_scalar_kalman_filter: random bursts of filter and
// process noise items, a bit-exact estimate predictor, and a stalling receiver.
// Depends on skf_pkg, skf_stream_if and the filter RTL.
module channel_scalar_kalman_filter_test;
  import skf_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint unsigned FIX_ONE = 64'd1 << FRAC;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 500;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 178;

  typedef struct {
    logic [REQ_W-1:0]        req;
    logic [CHAN_W-1:0]       ch;
    logic signed [SMP_W-1:0] raw;
    logic signed [SMP_W-1:0] last;
    logic [VAL_W-1:0]        noise;
  } request_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [R_W-1:0] cfg_wdata;

  skf_in_if  in_bus ();
  skf_out_if out_bus ();

  channel_scalar_kalman_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Predictor state: R, per-channel covariance and process noise
  logic [R_W-1:0]   obs_noise;
  logic [VAL_W-1:0] covariance [NUM_SLOTS];
  logic [VAL_W-1:0] proc_noise [NUM_SLOTS];
  int q_hundredths [NUM_SLOTS] = '{58, 60, 63, 53, 51, 53, 50, 52,
                                   52, 50, 53, 49, 57, 54, 50, 51};

  request_t pending [$];
  request_t on_bus;
  logic signed [SMP_W-1:0] estimates_due [$];
  logic signed [SMP_W-1:0] want_est;

  int mismatches = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int long_stall_req = 0;
  int long_stall_seen = 0;
  int idle_cycles = 0;
  int level [NUM_SLOTS];
  bit steady = 1'b0;
  logic [15:0] ready_mask = 16'hFFFF;
  logic [3:0] ready_slot = 4'd0;

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // One filter step: gain, truncated estimate, covariance update
  function automatic logic signed [SMP_W-1:0] kalman_update(input request_t r);
    logic [24:0] ptemp;
    longint unsigned den;
    longint unsigned gain;
    longint unsigned cov_next;
    longint acc;
    ptemp = {1'b0, covariance[r.ch]} + {1'b0, proc_noise[r.ch]};
    den = 64'(ptemp) + (64'(obs_noise) << FRAC);
    // zero R with zero Ptemp: take the limit of the ratio, unit gain
    if (den == 0) begin
      gain = FIX_ONE;
    end else begin
      gain = (64'(ptemp) << FRAC) / den;
    end
    acc = longint'(r.last) * longint'(FIX_ONE)
        + longint'(gain) * (longint'(r.raw) - longint'(r.last));
    acc = acc / longint'(FIX_ONE);
    cov_next = ((FIX_ONE - gain) * 64'(ptemp)) >> FRAC;
    covariance[r.ch] = (cov_next > 64'(VAL_MAX)) ? VAL_MAX : cov_next[VAL_W-1:0];
    return acc[SMP_W-1:0];
  endfunction

  function automatic request_t make_request(input logic [REQ_W-1:0] req,
                                            input logic [CHAN_W-1:0] ch,
                                            input logic signed [SMP_W-1:0] raw,
                                            input logic signed [SMP_W-1:0] last,
                                            input logic [VAL_W-1:0] noise);
    request_t r;
    r.req = req;
    r.ch = ch;
    r.raw = raw;
    r.last = last;
    r.noise = noise;
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] clamp16(input int v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[SMP_W-1:0];
  endfunction

  // Mostly tracked per-channel signals with noise, some full-range and noise writes
  function automatic request_t random_request();
    request_t r;
    int ch;
    int pick;
    int spread;
    ch = $urandom_range(NUM_SLOTS - 1);
    pick = $urandom_range(99);
    r = make_request(REQ_FILTER, ch[CHAN_W-1:0], 16'($urandom), 16'($urandom),
                     24'($urandom));
    if (pick < 12) begin
      r.req = REQ_WRITE;
      case ($urandom_range(3))
        0: r.noise = '0;
        1: r.noise = VAL_MAX;
        2: r.noise = 24'($urandom_range(0, 65535));
        default: r.noise = 24'($urandom);
      endcase
    end else if (pick < 72) begin
      spread = ($urandom_range(1) == 0) ? 50 : 5000;
      r.last = clamp16(level[ch] + $urandom_range(0, 2 * spread) - spread);
      r.raw = clamp16(level[ch] + $urandom_range(0, 2 * spread) - spread);
      level[ch] = clamp16(level[ch] + $urandom_range(0, 400) - 200);
    end else if (pick < 80) begin
      r.raw = ($urandom_range(1) == 0) ? 16'sh7FFF : 16'sh8000;
      r.last = ($urandom_range(1) == 0) ? 16'sh7FFF : 16'sh8000;
    end
    return r;
  endfunction

  // Change R only once the block is idle
  task automatic set_obs_noise(input logic [R_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    obs_noise = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pending.size() != 0 || estimates_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: offer queued items in bursts, hold an item until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (on_bus.req == REQ_WRITE) begin
          proc_noise[on_bus.ch] = on_bus.noise;
        end else begin
          estimates_due.push_back(kalman_update(on_bus));
        end
        void'(pending.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = (steady || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        on_bus = pending[0];
        in_bus.valid <= 1'b1;
        in_bus.req_type <= on_bus.req;
        in_bus.channel <= on_bus.ch;
        in_bus.raw_sample <= on_bus.raw;
        in_bus.last_estimate <= on_bus.last;
        in_bus.noise_value <= on_bus.noise;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall mask, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (long_stall_seen != long_stall_req) begin
      long_stall_seen = long_stall_req;
      hold_left = LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      if (ready_slot == 4'd0) begin
        ready_mask = (steady || $urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
      end
      out_bus.ready <= ready_mask[ready_slot];
      ready_slot = ready_slot + 4'd1;
    end
  end

  // Monitor: compare each taken estimate with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (estimates_due.size() == 0) begin
        report_mismatch($sformatf("estimate %0d with no item outstanding", out_bus.estimate));
      end else begin
        want_est = estimates_due.pop_front();
        if (out_bus.estimate !== want_est) begin
          report_mismatch($sformatf("estimate got %0d want %0d", out_bus.estimate, want_est));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_FILTER;
    in_bus.channel = '0;
    in_bus.raw_sample = '0;
    in_bus.last_estimate = '0;
    in_bus.noise_value = '0;
    out_bus.ready = 1'b0;
    obs_noise = R_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      covariance[i] = VAL_W'(FIX_ONE);
      proc_noise[i] = VAL_W'(((longint'(q_hundredths[i]) << FRAC) + 50) / 100);
      level[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset R: opposite extremes, equal inputs, saturated and zero noise
    pending.push_back(make_request(REQ_FILTER, 4'd0, 16'sh7FFF, 16'sh8000, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd1, 16'sh8000, 16'sh7FFF, VAL_MAX));
    pending.push_back(make_request(REQ_FILTER, 4'd2, 16'sd100, 16'sd100, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd4, 16'sd0, 16'sd0, '0));
    pending.push_back(make_request(REQ_WRITE, 4'd15, 16'sh7FFF, 16'sh7FFF, VAL_MAX));
    pending.push_back(make_request(REQ_FILTER, 4'd15, 16'sd1234, -16'sd1234, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd15, -16'sd1, 16'sd1, '0));
    pending.push_back(make_request(REQ_WRITE, 4'd3, 16'sh8000, 16'sh8000, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd3, 16'sd500, -16'sd500, '0));
    pending.push_back(make_request(REQ_WRITE, 4'd7, '0, '0, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd7, 16'sh7FFF, 16'sh7FFF, '0));
    drain_and_settle();

    // Zero R: drive channel 3 covariance to zero, then the zero-denominator case
    set_obs_noise('0);
    pending.push_back(make_request(REQ_FILTER, 4'd3, 16'sd20000, -16'sd20000, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd3, 16'sh8000, 16'sh7FFF, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd3, 16'sh7FFF, 16'sh8000, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd5, 16'sh7FFF, 16'sh8000, '0));
    drain_and_settle();

    // Largest R
    set_obs_noise(8'd255);
    pending.push_back(make_request(REQ_FILTER, 4'd6, 16'sh7FFF, 16'sh8000, '0));
    pending.push_back(make_request(REQ_WRITE, 4'd6, '0, '0, VAL_MAX));
    pending.push_back(make_request(REQ_FILTER, 4'd6, 16'sh8000, 16'sh7FFF, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd8, 16'sh8000, 16'sh8000, '0));
    drain_and_settle();

    // Smallest nonzero R
    set_obs_noise(8'd1);
    pending.push_back(make_request(REQ_FILTER, 4'd9, 16'sh8000, 16'sh7FFF, '0));
    pending.push_back(make_request(REQ_FILTER, 4'd9, 16'sh7FFF, 16'sh8000, '0));
    drain_and_settle();

    // Random phases, each under its own R and traffic shape
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_obs_noise(8'd1);
        1: set_obs_noise(8'd255);
        2: set_obs_noise(R_RESET);
        3: set_obs_noise(R_W'($urandom_range(2, 254)));
        4: set_obs_noise('0);
        5: set_obs_noise(R_W'($urandom_range(1, 255)));
        6: set_obs_noise(8'd128);
        default: set_obs_noise(R_W'($urandom));
      endcase
      steady = (p == 2 || p == 5);
      if (p == 3) begin
        long_stall_req++;
      end
      repeat (PHASE_ITEMS) pending.push_back(random_request());
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[channel_scalar_kalman_filter.f]
design/skf_pkg.sv
design/skf_stream_if.sv
design/skf_sequencer.sv
design/channel_scalar_kalman_filter.sv
bench/channel_scalar_kalman_filter_test.sv
